// ----- hw/rtl/vdpc_pkg.sv -----
`timescale 1ns / 1ps

package vdpc_pkg;

    // number of sample and rate ports on the top level
    localparam int IO_LANES = 4;

    // rate and timestamp width
    localparam int RATE_W = 32;

    // microseconds per second, scale applied to every difference
    localparam int US_W = 20;
    localparam logic [US_W-1:0] US_PER_S = 20'd1000000;

    // configuration register widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int VSIZE_W    = 3;

    // saturation limits
    localparam logic [RATE_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [RATE_W-1:0] NEG_LIMIT = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VECTOR_SIZE    = 3'd0,
        CFG_USE_DISCRETE   = 3'd1,
        CFG_USE_TIME_CHECK = 3'd2,
        CFG_SAMPLE_PERIOD  = 3'd3,
        CFG_ALLOWED_VAR    = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABS,
        ST_MUL,
        ST_INIT,
        ST_DIV,
        ST_DONE
    } state_t;

    // per-step strobes broadcast to every lane
    typedef struct packed {
        logic load;
        logic abs_en;
        logic mul_en;
        logic div_init;
        logic div_step;
    } lane_ctrl_t;

endpackage

// ----- hw/rtl/vector_derivative_with_period_check.sv -----
`timescale 1ns / 1ps

// one sample word at a time: sample_stall stays high from acceptance until the rate word
//   is loaded into the output register; each word runs accept, abs, multiply, divider
//   set-up, the 32-step restoring divider that each lane runs once per word, and
//   hand-off steps
// the rate word waits in an output register, a stalled rate word only holds the
//   sequencer in hand-off once the next word is ready
// reset: registers return to defaults, stored samples, rates and timestamp clear to zero

module vector_derivative_with_period_check #(
    parameter int LANES        = 4,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,

    // sample channel
    input  logic                                    sample_valid,
    output logic                                    sample_stall,
    input  logic signed [vdpc_pkg::RATE_W-1:0]      sample_0,
    input  logic signed [vdpc_pkg::RATE_W-1:0]      sample_1,
    input  logic signed [vdpc_pkg::RATE_W-1:0]      sample_2,
    input  logic signed [vdpc_pkg::RATE_W-1:0]      sample_3,
    input  logic        [vdpc_pkg::RATE_W-1:0]      time_now_us,

    // rate channel
    output logic                                    rate_valid,
    input  logic                                    rate_stall,
    output logic signed [vdpc_pkg::RATE_W-1:0]      rate_0,
    output logic signed [vdpc_pkg::RATE_W-1:0]      rate_1,
    output logic signed [vdpc_pkg::RATE_W-1:0]      rate_2,
    output logic signed [vdpc_pkg::RATE_W-1:0]      rate_3,
    output logic                                    held,

    // configuration write channel
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [vdpc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [vdpc_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int IOL = vdpc_pkg::IO_LANES;
    localparam int QW  = vdpc_pkg::RATE_W;
    localparam int NL  = (LANES < IOL) ? LANES : IOL;
    localparam int CNW = $clog2(QW);
    localparam int VW  = vdpc_pkg::VSIZE_W;
    localparam int PDW = vdpc_pkg::CFG_DATA_W;

    // configuration registers
    logic [VW-1:0]  cfg_vsize_reg;
    logic           cfg_discrete_reg;
    logic           cfg_tcheck_reg;
    logic [PDW-1:0] cfg_period_reg;
    logic [PDW-1:0] cfg_var_reg;

    // control
    vdpc_pkg::state_t     state_reg;
    vdpc_pkg::state_t     state_next;
    logic [CNW-1:0]       cnt_reg;
    logic [CNW-1:0]       cnt_next;
    vdpc_pkg::lane_ctrl_t ctrl;
    logic                 accept;
    logic                 out_free;
    logic                 out_load;

    // timing
    logic [QW-1:0]  last_time_reg;
    logic [QW-1:0]  dt_reg;
    logic [QW-1:0]  div_reg;
    logic           hold_reg;
    logic           hold_next;
    logic           lo_neg;
    logic [PDW-1:0] lo_mag;
    logic [PDW:0]   hi_win;

    // lanes
    logic [VW-1:0]               used;
    logic [NL-1:0]               active;
    logic signed [QW-1:0]        samp      [IOL];
    logic [QW-1:0]               lane_rate [NL];
    logic [QW-1:0]               rate_out  [IOL];

    assign cfg_ready    = 1'b1;
    assign sample_stall = (state_reg != vdpc_pkg::ST_IDLE);
    assign accept       = sample_valid && !sample_stall;

    // configuration writes, indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            cfg_vsize_reg    <= VW'(4);
            cfg_discrete_reg <= 1'b0;
            cfg_tcheck_reg   <= 1'b0;
            cfg_period_reg   <= PDW'(1000);
            cfg_var_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                vdpc_pkg::CFG_VECTOR_SIZE:    cfg_vsize_reg    <= cfg_data[VW-1:0];
                vdpc_pkg::CFG_USE_DISCRETE:   cfg_discrete_reg <= cfg_data[0];
                vdpc_pkg::CFG_USE_TIME_CHECK: cfg_tcheck_reg   <= cfg_data[0];
                vdpc_pkg::CFG_SAMPLE_PERIOD:  cfg_period_reg   <= cfg_data;
                vdpc_pkg::CFG_ALLOWED_VAR:    cfg_var_reg      <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // lane count clamped to one .. number of lanes built
    always_comb begin
        if (cfg_vsize_reg == '0)
        begin
            used = VW'(1);
        end
        else if (cfg_vsize_reg > VW'(NL))
        begin
            used = VW'(NL);
        end
        else
        begin
            used = cfg_vsize_reg;
        end
    end

    for (genvar i = 0; i < NL; i++) begin : g_active
        assign active[i] = (VW'(i) < used);
    end

    // state register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= vdpc_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // sequencer: abs, scale, divider set-up, 32 divider steps, hand-off
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ctrl          = '0;
        ctrl.load     = accept;
        out_load      = 1'b0;
        case (state_reg)
            vdpc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = vdpc_pkg::ST_ABS;
                end
            end
            vdpc_pkg::ST_ABS:
            begin
                ctrl.abs_en = 1'b1;
                state_next  = vdpc_pkg::ST_MUL;
            end
            vdpc_pkg::ST_MUL:
            begin
                ctrl.mul_en = 1'b1;
                state_next  = vdpc_pkg::ST_INIT;
            end
            vdpc_pkg::ST_INIT:
            begin
                ctrl.div_init = 1'b1;
                state_next    = vdpc_pkg::ST_DIV;
            end
            vdpc_pkg::ST_DIV:
            begin
                ctrl.div_step = 1'b1;
                if (cnt_reg == CNW'(QW - 1))
                begin
                    cnt_next   = '0;
                    state_next = vdpc_pkg::ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            vdpc_pkg::ST_DONE:
            begin
                // results wait here until the output register frees up
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = vdpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vdpc_pkg::ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // measured interval, wraps with the timer
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
        end
        else if (accept)
        begin
            last_time_reg <= time_now_us;
        end
    end

    // window check uses the measured interval even in discrete mode
    assign lo_neg    = cfg_var_reg > cfg_period_reg;
    assign lo_mag    = cfg_period_reg - cfg_var_reg;
    assign hi_win    = {1'b0, cfg_period_reg} + {1'b0, cfg_var_reg};
    assign hold_next = cfg_tcheck_reg &&
                       ((!lo_neg && (dt_reg < QW'(lo_mag))) || (dt_reg > QW'(hi_win)));

    always_ff @(posedge clk) begin
        if (accept)
        begin
            dt_reg <= time_now_us - last_time_reg;
        end
        if (ctrl.abs_en)
        begin
            hold_reg <= hold_next;
            div_reg  <= cfg_discrete_reg ? QW'(cfg_period_reg) : dt_reg;
        end
    end

    assign samp[0] = sample_0;
    assign samp[1] = sample_1;
    assign samp[2] = sample_2;
    assign samp[3] = sample_3;

    for (genvar i = 0; i < NL; i++) begin : g_lane
        vdpc_lane #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .active  (active[i]),
            .sample  (samp[i]),
            .divisor (div_reg),
            .rate    (lane_rate[i])
        );
    end

    // merge lane results, apply hold and unused-lane zeroing
    vdpc_merge #(
        .NL (NL)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .hold      (hold_reg),
        .active    (active),
        .lane_rate (lane_rate),
        .out_stall (rate_stall),
        .out_valid (rate_valid),
        .out_free  (out_free),
        .rate_out  (rate_out),
        .held      (held)
    );

    assign rate_0 = rate_out[0];
    assign rate_1 = rate_out[1];
    assign rate_2 = rate_out[2];
    assign rate_3 = rate_out[3];

    // a new rate word only comes out of the hand-off step
    a_rate_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rate_valid) |-> $past(state_reg == vdpc_pkg::ST_DONE))
        else $error("rate word raised outside hand-off");

    // held only with the time check enabled
    a_held_needs_check: assert property (@(posedge clk) disable iff (!rst_n)
        rate_valid && held |-> cfg_tcheck_reg)
        else $error("held raised with time check off");

    // divider step count only runs inside the divide phase
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != vdpc_pkg::ST_DIV |-> cnt_reg == '0)
        else $error("divider count out of phase");

    // an accepted sample word starts the abs step next
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == vdpc_pkg::ST_ABS)
        else $error("sequencer did not start");

endmodule

// ----- hw/rtl/vdpc_lane.sv -----
`timescale 1ns / 1ps

module vdpc_lane #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  vdpc_pkg::lane_ctrl_t                    ctrl,
    input  logic                                    active,
    input  logic signed [vdpc_pkg::RATE_W-1:0]      sample,
    input  logic        [vdpc_pkg::RATE_W-1:0]      divisor,
    output logic        [vdpc_pkg::RATE_W-1:0]      rate
);

    localparam int QW = vdpc_pkg::RATE_W;
    localparam int SW = SAMPLE_WIDTH;
    localparam int DW = SW + 1;
    localparam int NW = SW + 1 + vdpc_pkg::US_W;
    localparam int PW = (NW > QW + 1) ? NW : QW + 1;
    localparam int HW = PW - QW;
    localparam int CW = (HW > QW) ? HW : QW;

    logic signed [SW-1:0] samp_w;
    logic signed [SW-1:0] prev_sample_reg;
    logic signed [SW-1:0] prev_sample_next;
    logic signed [DW-1:0] diff_reg;
    logic signed [DW-1:0] diff_next;
    logic        [DW-1:0] mag_reg;
    logic        [DW-1:0] mag_next;
    logic                 neg_reg;
    logic                 zero_reg;
    logic                 sat_reg;
    logic        [NW-1:0] prod;
    logic        [PW-1:0] num_reg;
    logic        [HW-1:0] hi_part;
    logic        [CW-1:0] hi_x;
    logic        [CW-1:0] div_x;
    logic        [QW-1:0] rem_reg;
    logic        [QW-1:0] rem_next;
    logic        [QW-1:0] quo_reg;
    logic        [QW-1:0] quo_next;
    logic        [QW:0]   rem_sh;
    logic        [QW:0]   div_e;
    logic                 ge;
    logic        [QW-1:0] limit;
    logic        [QW-1:0] mag_r;

    // the sample word is taken at the configured width
    if (SW <= QW) begin : g_narrow
        assign samp_w = sample[SW-1:0];
    end else begin : g_wide
        assign samp_w = {{(SW-QW){1'b0}}, sample};
    end

    assign diff_next        = DW'(samp_w) - DW'(prev_sample_reg);
    assign prev_sample_next = active ? samp_w : '0;
    assign mag_next         = diff_reg[DW-1] ? (~diff_reg + 1'b1) : diff_reg;
    assign prod             = NW'(mag_reg) * NW'(vdpc_pkg::US_PER_S);

    // upper part of the scaled difference decides saturation up front
    assign hi_part = num_reg[PW-1:QW];
    assign hi_x    = CW'(hi_part);
    assign div_x   = CW'(divisor);

    // one restoring step per cycle
    assign rem_sh   = {rem_reg, quo_reg[QW-1]};
    assign div_e    = {1'b0, divisor};
    assign ge       = rem_sh >= div_e;
    assign rem_next = ge ? QW'(rem_sh - div_e) : rem_sh[QW-1:0];
    assign quo_next = {quo_reg[QW-2:0], ge};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            prev_sample_reg <= '0;
        end
        else if (ctrl.load)
        begin
            prev_sample_reg <= prev_sample_next;
        end
    end

    always_ff @(posedge clk) begin
        if (ctrl.load)
        begin
            diff_reg <= diff_next;
        end
        if (ctrl.abs_en)
        begin
            neg_reg <= diff_reg[DW-1];
            mag_reg <= mag_next;
        end
        if (ctrl.mul_en)
        begin
            num_reg  <= PW'(prod);
            zero_reg <= (mag_reg == '0);
        end
        if (ctrl.div_init)
        begin
            sat_reg <= (hi_x >= div_x);
            rem_reg <= hi_x[QW-1:0];
            quo_reg <= num_reg[QW-1:0];
        end
        else if (ctrl.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // clamp by sign, then restore the sign
    assign limit = neg_reg ? vdpc_pkg::NEG_LIMIT : vdpc_pkg::POS_LIMIT;
    assign mag_r = (sat_reg || (quo_reg > limit)) ? limit : quo_reg;

    always_comb begin
        if (zero_reg)
        begin
            rate = '0;
        end
        else if (neg_reg)
        begin
            rate = ~mag_r + 1'b1;
        end
        else
        begin
            rate = mag_r;
        end
    end

endmodule

// ----- hw/rtl/vdpc_merge.sv -----
`timescale 1ns / 1ps

module vdpc_merge #(
    parameter int NL = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  logic                            hold,
    input  logic [NL-1:0]                   active,
    input  logic [vdpc_pkg::RATE_W-1:0]     lane_rate [NL],
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic                            out_free,
    output logic [vdpc_pkg::RATE_W-1:0]     rate_out [vdpc_pkg::IO_LANES],
    output logic                            held
);

    logic [vdpc_pkg::RATE_W-1:0] prev_rate_reg [NL];
    logic [vdpc_pkg::RATE_W-1:0] sel          [NL];
    logic [vdpc_pkg::RATE_W-1:0] rate_reg     [NL];
    logic                        valid_reg;
    logic                        held_reg;

    assign out_free  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign held      = held_reg;

    for (genvar i = 0; i < vdpc_pkg::IO_LANES; i++) begin : g_lane
        if (i < NL) begin : g_used
            // unused lanes read zero, held lanes repeat the last word
            assign sel[i] = !active[i] ? '0 : (hold ? prev_rate_reg[i] : lane_rate[i]);

            always_ff @(posedge clk or negedge rst_n) begin
                if (!rst_n)
                begin
                    prev_rate_reg[i] <= '0;
                end
                else if (load)
                begin
                    prev_rate_reg[i] <= sel[i];
                end
            end

            always_ff @(posedge clk) begin
                if (load)
                begin
                    rate_reg[i] <= sel[i];
                end
            end

            assign rate_out[i] = rate_reg[i];
        end else begin : g_absent
            assign rate_out[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (load)
        begin
            held_reg <= hold;
        end
    end

endmodule

// ----- dv/vector_derivative_with_period_check_test.sv -----
`timescale 1ns / 1ps

module vector_derivative_with_period_check_test;

    import vdpc_pkg::*;

    // run shape
    localparam int PHASES          = 10;
    localparam int WORDS_PER_PHASE = 95;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int REPORT_MAX      = 10;
    localparam int IDLE_PCT        = 28;

    // one sample word as it crosses the sample channel
    typedef struct packed {
        logic [IO_LANES-1:0][RATE_W-1:0] samp;
        logic [RATE_W-1:0]               stamp;
    } sample_word_t;

    // one rate word as it crosses the rate channel
    typedef struct packed {
        logic [IO_LANES-1:0][RATE_W-1:0] rate;
        logic                            held;
    } rate_word_t;

    // hand-written expectation riding along with a directed word
    typedef struct packed {
        logic       known;
        rate_word_t result;
    } typed_t;

    // directed table row: a register write or a sample word
    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        sample_word_t          word;
        logic                  known;
        rate_word_t            result;
    } dir_row_t;

    // clock, reset and block ports, inputs known from time zero
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_stall;
    logic [RATE_W-1:0]     sample_0     = '0;
    logic [RATE_W-1:0]     sample_1     = '0;
    logic [RATE_W-1:0]     sample_2     = '0;
    logic [RATE_W-1:0]     sample_3     = '0;
    logic [RATE_W-1:0]     time_now_us  = '0;
    logic                  rate_valid;
    logic                  rate_stall   = 1'b0;
    logic [RATE_W-1:0]     rate_0;
    logic [RATE_W-1:0]     rate_1;
    logic [RATE_W-1:0]     rate_2;
    logic [RATE_W-1:0]     rate_3;
    logic                  held;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    // register mirror, reset values of the block
    logic [VSIZE_W-1:0]    m_vsize    = 3'd4;
    logic                  m_discrete = 1'b0;
    logic                  m_check    = 1'b0;
    logic [CFG_DATA_W-1:0] m_period   = 20'd1000;
    logic [CFG_DATA_W-1:0] m_var      = '0;

    // lane state as the block keeps it
    longint                prior_samp [IO_LANES];
    logic [RATE_W-1:0]     prior_rate [IO_LANES];
    logic [RATE_W-1:0]     prior_stamp;

    // last values actually sent, used to shape the next word
    logic [RATE_W-1:0]     sent_samp [IO_LANES];
    logic [RATE_W-1:0]     sent_stamp;

    rate_word_t            rates_due [$];
    typed_t                typed_due [$];
    dir_row_t              plan [$];

    // driver bookkeeping; offer_up and cfg_up shadow the valids so each is
    // lowered at most once per step
    logic                  offer_up = 1'b0;
    logic                  cfg_up   = 1'b0;
    logic                  calm     = 1'b0;

    int                    words_sent  = 0;
    int                    words_done  = 0;
    int                    fails       = 0;
    int                    held_count  = 0;
    int                    sat_lanes   = 0;
    int                    reg_writes  = 0;
    int                    cycle_count = 0;

    vector_derivative_with_period_check i_dut (.*);

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one lane: diff * 1e6 / div, truncated toward zero, saturated by sign
    function automatic logic [RATE_W-1:0] lane_rate(longint diff, logic [RATE_W-1:0] div);
        logic              neg;
        logic [RATE_W-1:0] sat;
        longint unsigned   mag, lim, dv, scale, whole, part, res;
        neg   = diff < 0;
        sat   = neg ? NEG_LIMIT : POS_LIMIT;
        mag   = neg ? -diff : diff;
        lim   = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        dv    = div;
        scale = US_PER_S;
        // zero difference wins over a zero divisor
        if (mag == 0)
            return '0;
        if (dv == 0)
            return sat;
        whole = mag / dv;
        part  = mag % dv;
        if (whole > 64'hFFFF_FFFF)
            return sat;
        res = whole * scale + (part * scale) / dv;
        if (res > lim)
            return sat;
        return neg ? RATE_W'(-res) : res[RATE_W-1:0];
    endfunction

    // expected rate word for an accepted sample word, advances lane state
    function automatic rate_word_t derive_rates(sample_word_t w);
        rate_word_t        o;
        logic [RATE_W-1:0] dt, div;
        longint            lo, hi, cur;
        int                lanes;
        logic              hold;
        dt    = w.stamp - prior_stamp;                  // wraps modulo 2^32
        div   = m_discrete ? RATE_W'(m_period) : dt;
        lanes = (m_vsize == 0) ? 1 : ((m_vsize > IO_LANES) ? IO_LANES : int'(m_vsize));
        // window uses the measured interval, discrete mode or not
        lo    = longint'(m_period) - longint'(m_var);
        hi    = longint'(m_period) + longint'(m_var);
        hold  = m_check && (longint'(dt) < lo || longint'(dt) > hi);
        o      = '0;
        o.held = hold;
        for (int k = 0; k < IO_LANES; k++)
        begin
            if (k < lanes)
            begin
                cur = longint'($signed(w.samp[k]));
                o.rate[k] = hold ? prior_rate[k] : lane_rate(cur - prior_samp[k], div);
                prior_samp[k] = cur;
            end
            else
                prior_samp[k] = 0;                  // unused lanes clear
            prior_rate[k] = o.rate[k];
            if (o.rate[k] == POS_LIMIT || o.rate[k] == NEG_LIMIT)
                sat_lanes++;
        end
        prior_stamp = w.stamp;
        if (hold)
            held_count++;
        return o;
    endfunction

    // compare one rate word against the oldest expectation
    function automatic void check_word(rate_word_t got);
        rate_word_t want;
        words_done++;
        if (rates_due.size() == 0)
        begin
            fails++;
            if (fails <= REPORT_MAX)
                $display("rate word %0d arrived with nothing expected: %h %h %h %h held %b",
                         words_done, got.rate[0], got.rate[1], got.rate[2], got.rate[3],
                         got.held);
            return;
        end
        want = rates_due.pop_front();
        if (got.rate[0] !== want.rate[0] || got.rate[1] !== want.rate[1] ||
            got.rate[2] !== want.rate[2] || got.rate[3] !== want.rate[3] ||
            got.held !== want.held)
        begin
            fails++;
            if (fails <= REPORT_MAX)
                $display("rate word %0d: expected %h %h %h %h held %b, got %h %h %h %h held %b",
                         words_done, want.rate[0], want.rate[1], want.rate[2], want.rate[3],
                         want.held, got.rate[0], got.rate[1], got.rate[2], got.rate[3],
                         got.held);
        end
    endfunction

    // sample side: predict at every accepted word
    always @(posedge clk)
    begin : take_word
        typed_t tag;
        rate_word_t guess;
        if (rst_n && sample_valid && !sample_stall)
        begin
            tag   = typed_due.pop_front();
            guess = derive_rates({sample_3, sample_2, sample_1, sample_0, time_now_us});
            // typed rows carry their own answer, state still advances
            rates_due.push_back(tag.known ? tag.result : guess);
        end
    end

    // rate side: check accepted words, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && rate_valid && !rate_stall)
            check_word({rate_3, rate_2, rate_1, rate_0, held});
        rate_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // directed table builders
    function automatic void dir_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        dir_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        plan.push_back(row);
    endfunction

    function automatic void dir_word(logic [RATE_W-1:0] s0, s1, s2, s3, t,
                                     logic known = 1'b0,
                                     logic [RATE_W-1:0] r0 = '0, r1 = '0, r2 = '0, r3 = '0);
        dir_row_t row;
        row            = '0;
        row.word.samp  = {s3, s2, s1, s0};
        row.word.stamp = t;
        row.known      = known;
        row.result     = {r3, r2, r1, r0, 1'b0};
        plan.push_back(row);
    endfunction

    task automatic stop_offer();
        if (offer_up)
            sample_valid <= 1'b0;
        offer_up = 1'b0;
    endtask

    task automatic stop_cfg();
        if (cfg_up)
            cfg_valid <= 1'b0;
        cfg_up = 1'b0;
    endtask

    // hold the sender until every rate word in flight is back
    task automatic drain();
        stop_offer();
        while (words_done != words_sent)
            @(posedge clk);
    endtask

    // register write, only with the block idle; valid stays up for a
    // following write and drops on the next sample word
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_up     = 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        reg_writes++;
        case (idx)
            CFG_VECTOR_SIZE:    m_vsize    = data[VSIZE_W-1:0];
            CFG_USE_DISCRETE:   m_discrete = data[0];
            CFG_USE_TIME_CHECK: m_check    = data[0];
            CFG_SAMPLE_PERIOD:  m_period   = data;
            CFG_ALLOWED_VAR:    m_var      = data;
            default: ;                              // unmapped index, ignored
        endcase
    endtask

    // offer one sample word after a random gap, wait for it to be taken
    task automatic push_word(sample_word_t w, logic known, rate_word_t result);
        typed_t tag;
        stop_cfg();
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            stop_offer();
            @(posedge clk);
        end
        tag.known  = known;
        tag.result = result;
        typed_due.push_back(tag);
        sample_valid <= 1'b1;
        offer_up      = 1'b1;
        {sample_3, sample_2, sample_1, sample_0} <= w.samp;
        time_now_us  <= w.stamp;
        do
            @(posedge clk);
        while (sample_stall);
        words_sent++;
        for (int k = 0; k < IO_LANES; k++)
            sent_samp[k] = w.samp[k];
        sent_stamp = w.stamp;
    endtask

    // random word: mostly near-period timestamps and modest steps, with
    // some full-range noise, extremes and repeats
    function automatic sample_word_t random_word();
        sample_word_t w;
        longint       span, off;
        int unsigned  bits_k, d;
        span = longint'(m_var) + 2;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                // around the window edges
                off     = longint'($urandom_range(0, 32'(2 * span))) - span;
                w.stamp = sent_stamp + RATE_W'(longint'(m_period) + off);
            end
            6, 7:    w.stamp = sent_stamp + $urandom_range(0, 2 * m_period + 10);
            8:       w.stamp = $urandom();
            default: w.stamp = sent_stamp + $urandom_range(0, 3);
        endcase
        for (int k = 0; k < IO_LANES; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    bits_k = $urandom_range(0, 24);
                    d      = $urandom_range(0, 1 << bits_k);
                    w.samp[k] = $urandom_range(0, 1) ? sent_samp[k] - d : sent_samp[k] + d;
                end
                6, 7: w.samp[k] = $urandom();
                8:
                begin
                    case ($urandom_range(0, 3))
                        0:       w.samp[k] = POS_LIMIT;
                        1:       w.samp[k] = NEG_LIMIT;
                        2:       w.samp[k] = '0;
                        default: w.samp[k] = '1;
                    endcase
                end
                default: w.samp[k] = sent_samp[k];      // zero difference
            endcase
        end
        return w;
    endfunction

    // one register setting per phase, fixed extremes first, then random
    task automatic set_phase(int p);
        logic [VSIZE_W-1:0]    vs;
        logic                  disc, chk;
        logic [CFG_DATA_W-1:0] per, var_us;
        case (p)
            0:       {vs, disc, chk, per, var_us} = {3'd4, 1'b0, 1'b0, 20'd1000, 20'd0};
            1:       {vs, disc, chk, per, var_us} = {3'd4, 1'b0, 1'b1, 20'd1000, 20'd50};
            2:       {vs, disc, chk, per, var_us} = {3'd1, 1'b1, 1'b0, 20'd1000, 20'd0};
            3:       {vs, disc, chk, per, var_us} = {3'd4, 1'b1, 1'b1, 20'd0, 20'd0};
            4:       {vs, disc, chk, per, var_us} = {3'd7, 1'b0, 1'b1, 20'hFFFFF, 20'hFFFFF};
            5:       {vs, disc, chk, per, var_us} = {3'd0, 1'b1, 1'b1, 20'd1000000, 20'd1000000};
            default:
            begin
                vs     = $urandom_range(0, 7);
                disc   = $urandom_range(0, 1);
                chk    = $urandom_range(0, 1);
                per    = $urandom_range(1, 5000);
                var_us = $urandom_range(0, per / 4);
            end
        endcase
        // upper data bits are don't-care for the narrow registers
        write_reg(CFG_VECTOR_SIZE, CFG_DATA_W'({$urandom(), vs}));
        write_reg(CFG_USE_DISCRETE, CFG_DATA_W'({$urandom(), disc}));
        write_reg(CFG_USE_TIME_CHECK, CFG_DATA_W'({$urandom(), chk}));
        write_reg(CFG_SAMPLE_PERIOD, per);
        write_reg(CFG_ALLOWED_VAR, var_us);
        // a write to an unmapped index must leave every register alone
        if (p >= 6)
            write_reg(CFG_IDX_W'(CFG_ALLOWED_VAR) + CFG_IDX_W'($urandom_range(1, 3)),
                      CFG_DATA_W'($urandom()));
    endtask

    // watchdog
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("no end of run after %0d cycles", CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int calm_phase;
        for (int k = 0; k < IO_LANES; k++)
        begin
            prior_samp[k] = 0;
            prior_rate[k] = '0;
            sent_samp[k]  = '0;
        end
        prior_stamp = '0;
        sent_stamp  = '0;
        calm_phase  = $urandom_range(0, PHASES - 1);

        // reset defaults: four lanes, measured time, no window check
        // all zero at time zero: zero difference over zero interval
        dir_word('0, '0, '0, '0, 32'd0, 1'b1, '0, '0, '0, '0);
        // zero interval with nonzero differences saturates by sign
        dir_word(32'd1, '1, POS_LIMIT, NEG_LIMIT, 32'd0, 1'b1,
                 POS_LIMIT, NEG_LIMIT, POS_LIMIT, NEG_LIMIT);
        // same samples again: zero rates
        dir_word(32'd1, '1, POS_LIMIT, NEG_LIMIT, 32'd1000, 1'b1, '0, '0, '0, '0);
        // full-scale swings over one microsecond overflow
        dir_word(NEG_LIMIT, POS_LIMIT, NEG_LIMIT, POS_LIMIT, 32'd1001, 1'b1,
                 NEG_LIMIT, POS_LIMIT, NEG_LIMIT, POS_LIMIT);
        // ordinary steps over the nominal period
        dir_word(32'h8001_0000, 32'h7FFF_0000, 32'h8000_0100, 32'h7FFF_FF00, 32'd2001);
        // timer wrap
        dir_word('0, '0, '0, '0, 32'hFFFF_FF00);
        dir_word(32'h0001_0000, 32'hFFFF_8000, 32'h0000_0001, 32'hFFF0_0000, 32'h0000_0100);
        // lane count zero acts as one lane
        dir_cfg(CFG_VECTOR_SIZE, 20'd0);
        dir_word(32'h0003_0000, 32'h0002_0000, 32'h1234_5678, 32'h8765_4321, 32'h0000_0600);
        // lane count above four clamps to four
        dir_cfg(CFG_VECTOR_SIZE, 20'd7);
        dir_word(32'h0002_8000, 32'hFFFE_0000, 32'h0000_4000, 32'h7FFF_0000, 32'h0000_0A00);
        dir_cfg(CFG_VECTOR_SIZE, 20'd2);
        dir_word(32'h0001_0000, 32'h0001_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0E00);
        // discrete mode with zero period
        dir_cfg(CFG_USE_DISCRETE, 20'd1);
        dir_cfg(CFG_SAMPLE_PERIOD, 20'd0);
        dir_word(32'h0002_0000, 32'hFFFF_0000, '0, '0, 32'h0000_1000);
        // discrete mode, period equal to the microseconds-per-second scale
        dir_cfg(CFG_SAMPLE_PERIOD, 20'd1000000);
        dir_word(32'h7FFF_FFFF, 32'h8000_0000, '0, '0, 32'h0000_1200);
        // window 900..1100: both edges in, one past each edge held
        dir_cfg(CFG_USE_DISCRETE, 20'd0);
        dir_cfg(CFG_SAMPLE_PERIOD, 20'd1000);
        dir_cfg(CFG_ALLOWED_VAR, 20'd100);
        dir_cfg(CFG_USE_TIME_CHECK, 20'd1);
        dir_cfg(CFG_VECTOR_SIZE, 20'd4);
        dir_word(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'd5508);
        dir_word(32'h0002_0000, 32'h0001_0000, 32'h0004_0000, 32'h0003_0000, 32'd6608);
        dir_word(32'h0009_0000, 32'h0000_0000, 32'hFFFF_0000, 32'h0010_0000, 32'd7507);
        dir_word(32'h0000_1000, 32'h0100_0000, 32'h0000_0000, 32'h0000_0001, 32'd8608);
        // window check still uses measured time in discrete mode
        dir_cfg(CFG_USE_DISCRETE, 20'd1);
        dir_word(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'd9608);
        dir_word(32'h0005_0000, 32'h0000_0000, 32'h0002_0000, 32'h0003_0000, 32'd14608);
        // lower window edge below zero, zero divisor in discrete mode
        dir_cfg(CFG_SAMPLE_PERIOD, 20'd0);
        dir_cfg(CFG_ALLOWED_VAR, 20'd1000000);
        dir_word(32'h0006_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0004_0000, 32'd1014608);
        dir_word(32'h0007_0000, 32'h0000_0000, 32'h0001_0000, 32'h0004_0000, 32'd2014609);

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_reg(plan[i].idx, plan[i].data);
            else
                push_word(plan[i].word, plan[i].known, plan[i].result);
        end

        // random phases, one setting each; one phase runs without any idling
        for (int p = 0; p < PHASES; p++)
        begin
            set_phase(p);
            calm = (p == calm_phase);
            for (int i = 0; i < WORDS_PER_PHASE; i++)
            begin
                // in phase 1 only, the sender waits once mid-phase for the pipeline to empty
                if (p == 1 && i == WORDS_PER_PHASE / 2)
                    drain();
                push_word(random_word(), 1'b0, '0);
            end
        end
        drain();
        calm = 1'b0;

        // quiet tail to catch stray rate words
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (rates_due.size() != 0)
        begin
            fails += rates_due.size();
            $display("%0d rate words never arrived", rates_due.size());
        end

        $display("covered %0d sample words over %0d register writes and %0d settings",
                 words_sent, reg_writes, PHASES);
        $display("held words %0d, saturated lanes %0d, failures %0d, cycles %0d",
                 held_count, sat_lanes, fails, cycle_count);
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
